/* hw/rtl/xsrg_pkg.sv */
// ----------------------------------------------------------------------------
// xsrg_pkg
// Shared types and constants for the xorshift128 range generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xsrg_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] EXPAND_MULT = 32'd1812433253;
  localparam int unsigned SHIFT_A = 11;
  localparam int unsigned SHIFT_B = 19;
  localparam int unsigned SHIFT_C = 8;

  localparam logic [1:0] LOAD_STEPS = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WORD_W - 1);

  localparam logic REQ_RAW   = 1'b0;
  localparam logic REQ_RANGE = 1'b1;

  typedef enum logic [1:0] {
    KIND_RAW,
    KIND_HOLD,
    KIND_UP,
    KIND_DOWN
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] divisor;
  } entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIVIDE,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

/* hw/rtl/xsrg_front.sv */
// ----------------------------------------------------------------------------
// xsrg_front
// Seed expansion, xorshift128 state, request classification and queue push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsrg_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [xsrg_pkg::WORD_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic [xsrg_pkg::WORD_W-1:0]   range_low,
  input  wire logic [xsrg_pkg::WORD_W-1:0]   range_high,
  output logic                               push,
  output xsrg_pkg::entry_t                   push_entry,
  input  wire logic                          q_full
);
  import xsrg_pkg::*;

  logic [1:0]        load_cnt;
  logic [WORD_W-1:0] s0;
  logic [WORD_W-1:0] s1;
  logic [WORD_W-1:0] s2;
  logic [WORD_W-1:0] s3;
  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] s3_next;
  logic [WORD_W-1:0] expand_next;
  logic              accept;
  logic              do_step;

  assign in_ready    = (load_cnt == 2'd0) && !q_full;
  assign accept      = in_valid && in_ready;
  assign t           = s0 ^ (s0 << SHIFT_A);
  assign s3_next     = s3 ^ (s3 >> SHIFT_B) ^ t ^ (t >> SHIFT_C);
  assign expand_next = s3 * EXPAND_MULT + 32'd1;
  assign do_step     = (req_type == REQ_RAW) || (range_low != range_high);

  always_comb begin
    push_entry.word    = s3_next;
    push_entry.base    = range_low;
    push_entry.divisor = range_high - range_low;
    if (req_type == REQ_RAW) begin
      push_entry.kind = KIND_RAW;
    end else if (range_low == range_high) begin
      push_entry.kind = KIND_HOLD;
    end else if ($signed(range_low) < $signed(range_high)) begin
      push_entry.kind = KIND_UP;
    end else begin
      push_entry.kind    = KIND_DOWN;
      push_entry.divisor = range_low - range_high;
    end
  end

  assign push = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt <= LOAD_STEPS;
      s3       <= '0;
    end else if (cfg_wr_en) begin
      load_cnt <= LOAD_STEPS;
      s3       <= cfg_wr_data;
    end else if (load_cnt != 2'd0) begin
      load_cnt <= load_cnt - 2'd1;
      s0       <= s1;
      s1       <= s2;
      s2       <= s3;
      s3       <= expand_next;
    end else if (accept && do_step) begin
      s0 <= s1;
      s1 <= s2;
      s2 <= s3;
      s3 <= s3_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xsrg_fifo.sv */
// ----------------------------------------------------------------------------
// xsrg_fifo
// Short request queue between the front and the divide back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsrg_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire xsrg_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output xsrg_pkg::entry_t      head,
  output logic                  empty
);
  import xsrg_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xsrg_back.sv */
// ----------------------------------------------------------------------------
// xsrg_back
// Bit-serial remainder unit and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsrg_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire xsrg_pkg::entry_t            head,
  input  wire logic                        q_empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [xsrg_pkg::WORD_W-1:0]      out_raw,
  output logic [xsrg_pkg::WORD_W-1:0]      out_value,
  output logic                             out_stepped
);
  import xsrg_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  kind_t                kind;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    base;
  logic [WORD_W-1:0]    divisor;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    dvd;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      shifted;
  logic                 load_out;
  logic [WORD_W-1:0]    res_word;
  logic [WORD_W-1:0]    res_value;
  logic                 res_stepped;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = (head.kind inside {KIND_UP, KIND_DOWN}) ? B_DIVIDE : B_DONE;
        end
      end
      B_DIVIDE: begin
        if (cnt == '0) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && !q_empty;
    load_out = (state == B_DONE) && (!out_valid || out_ready);
  end

  assign shifted = {rem, dvd[WORD_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_comb begin
    case (kind)
      KIND_RAW: begin
        res_word    = word;
        res_value   = '0;
        res_stepped = 1'b1;
      end
      KIND_HOLD: begin
        res_word    = '0;
        res_value   = base;
        res_stepped = 1'b0;
      end
      KIND_UP: begin
        res_word    = word;
        res_value   = base + rem;
        res_stepped = 1'b1;
      end
      default: begin
        res_word    = word;
        res_value   = base - rem;
        res_stepped = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind    <= head.kind;
      word    <= head.word;
      base    <= head.base;
      divisor <= head.divisor;
      rem     <= '0;
      dvd     <= head.word;
      cnt     <= DIV_LAST;
    end else if (state == B_DIVIDE) begin
      rem <= trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
      dvd <= dvd << 1;
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_raw     <= res_word;
      out_value   <= res_value;
      out_stepped <= res_stepped;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xorshift128_range_generator.sv */
// ----------------------------------------------------------------------------
// xorshift128_range_generator
// xorshift128 generator with raw and integer range draws.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit up)             | tuser
//  ----------+-----+--------------------------------+-----------
//  s_axis    | in  | range_low[31:0], range_high    | req_type
//  m_axis    | out | raw_word[31:0], range_value    | stepped
//  cfg       | in  | cfg_wr_data = seed             | -
//
//  A request is written into the queue when accepted; the back end pops it when idle.
//  Range draws with distinct bounds pass through pop, 32 remainder steps and
//  result load in the back end; raw and equal-bound draws skip the remainder steps.
//  Reset and each seed write expand the seed while holding s_axis_tready low.
//  A stalled m_axis holds its result while up to 2 requests wait in the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xorshift128_range_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // range_low[31:0], range_high[63:32]
  input  wire logic [0:0]  s_axis_tuser,   // req_type[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // raw_word[31:0], range_value[63:32]
  output logic [0:0]       m_axis_tuser    // stepped[0]
);
  import xsrg_pkg::*;

  logic              push;
  entry_t            push_entry;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  entry_t            head;
  logic [WORD_W-1:0] out_raw;
  logic [WORD_W-1:0] out_value;
  logic              out_stepped;

  xsrg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .req_type    (s_axis_tuser[0]),
    .range_low   (s_axis_tdata[31:0]),
    .range_high  (s_axis_tdata[63:32]),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  xsrg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  xsrg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_raw     (out_raw),
    .out_value   (out_value),
    .out_stepped (out_stepped)
  );

  assign m_axis_tdata = {out_value, out_raw};
  assign m_axis_tuser = out_stepped;

endmodule

`default_nettype wire

/* hw/rtl/xsrg_checker.sv */
// ----------------------------------------------------------------------------
// xsrg_checker
// Port-level checks for the xorshift128 range generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsrg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_wr_en,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input accepted during seed expansion after reset");

  a_seed_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> !s_axis_tready)
    else $error("input accepted during seed expansion after write");

  a_hold_no_word: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("unstepped transaction carries a raw word");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output transaction changed");

endmodule

bind xorshift128_range_generator xsrg_checker u_xsrg_checker (.*);

`default_nettype wire

/* tb/xorshift128_range_generator_tb.sv */
// ----------------------------------------------------------------------------
// xorshift128_range_generator_tb
// Self-checking testbench for the xorshift128 range generator. A directed
// table covers equal, rising and falling bounds at the extremes, then seeded
// phases drive random raw and range draws. Every result is compared against
// an in-bench xorshift128 predictor, with random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xorshift128_range_generator_tb;

  import xsrg_pkg::*;

  typedef struct packed {
    logic [31:0] raw_word;
    logic [31:0] range_value;
    logic        stepped;
  } draw_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] lo;
    logic [31:0] hi;
    bit          typed;
    logic [31:0] exp_raw;
    logic [31:0] exp_value;
    logic        exp_stepped;
  } stim_row_t;

  localparam int DIRECTED_N = 23;
  localparam int PHASE_N = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLDOFF_LEN = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;    // range_low[31:0], range_high[63:32]
  logic [0:0]  s_axis_tuser;    // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;    // raw_word[31:0], range_value[63:32]
  logic [0:0]  m_axis_tuser;    // stepped[0]

  logic [31:0] gen_word [4];
  draw_t       expected_draws [$];
  int unsigned count_by_kind [4];
  int unsigned seed_loads = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  bit          idle_on = 1'b1;
  int          holdoff_cycles = 0;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{REQ_RAW,   32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RAW,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0, 32'h0000_0000, 1'b0},
    '{REQ_RANGE, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0, 32'h8000_0000, 1'b0},
    '{REQ_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0, 32'h7FFF_FFFF, 1'b0},
    '{REQ_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'hFFFF_FFFF, 1'b0},
    '{REQ_RANGE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h8000_0000, 32'h8000_0001, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'hFFFF_FF9C, 32'h0000_0064, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h0000_0064, 32'hFFFF_FF9C, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h0000_0005, 32'h0000_0011, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RAW,   32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{REQ_RANGE, 32'h5555_5555, 32'h5555_5555, 1'b1, 32'h0, 32'h5555_5555, 1'b0},
    '{REQ_RANGE, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b1, 32'h0, 32'hAAAA_AAAA, 1'b0}
  };

  xorshift128_range_generator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic void expand_seed(input logic [31:0] seed);
    gen_word[0] = seed;
    for (int i = 1; i < 4; i++) begin
      gen_word[i] = gen_word[i-1] * EXPAND_MULT + 32'd1;
    end
    seed_loads++;
  endfunction

  function automatic logic [31:0] next_word();
    logic [31:0] t;
    t = gen_word[0] ^ (gen_word[0] << SHIFT_A);
    gen_word[0] = gen_word[1];
    gen_word[1] = gen_word[2];
    gen_word[2] = gen_word[3];
    gen_word[3] = gen_word[3] ^ (gen_word[3] >> SHIFT_B) ^ t ^ (t >> SHIFT_C);
    return gen_word[3];
  endfunction

  function automatic draw_t predict_draw(input logic kind, input logic [31:0] lo,
                                         input logic [31:0] hi);
    draw_t       r;
    logic [31:0] w;
    r = '0;
    if (kind == REQ_RAW) begin
      r.raw_word = next_word();
      r.stepped = 1'b1;
      count_by_kind[KIND_RAW]++;
    end else if (lo == hi) begin
      r.range_value = lo;
      count_by_kind[KIND_HOLD]++;
    end else begin
      w = next_word();
      r.raw_word = w;
      r.stepped = 1'b1;
      if ($signed(lo) < $signed(hi)) begin
        r.range_value = lo + w % (hi - lo);
        count_by_kind[KIND_UP]++;
      end else begin
        r.range_value = lo - w % (lo - hi);
        count_by_kind[KIND_DOWN]++;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(input logic kind, input logic [31:0] lo, input logic [31:0] hi,
                              input bit typed, input draw_t typed_draw);
    draw_t want;
    while (idle_on && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hi, lo};
    s_axis_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready);
    want = predict_draw(kind, lo, hi);
    if (typed) begin
      want = typed_draw;
    end
    expected_draws.push_back(want);
  endtask

  task automatic drain_results();
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= seed;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    expand_seed(seed);
  endtask

  task automatic report_mismatch(input string what, input draw_t want, input draw_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s at result %0d: expected raw=%h value=%h stepped=%b,",
               $realtime, what, results_seen, want.raw_word, want.range_value, want.stepped);
      $display("  got raw=%h value=%h stepped=%b", got.raw_word, got.range_value, got.stepped);
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    draw_t got;
    draw_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.raw_word = m_axis_tdata[31:0];
      got.range_value = m_axis_tdata[63:32];
      got.stepped = m_axis_tuser[0];
      if (expected_draws.size() == 0) begin
        report_mismatch("unexpected transaction", '0, got);
      end else begin
        want = expected_draws.pop_front();
        if (got.raw_word !== want.raw_word || got.range_value !== want.range_value ||
            got.stepped !== want.stepped) begin
          report_mismatch("mismatch", want, got);
        end
      end
      results_seen++;
    end
  end

  // receiver: random backpressure plus an occasional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (holdoff_cycles) @(posedge clk);
        holdoff_cycles = 0;
      end
      m_axis_tready <= !(idle_on && $urandom_range(99) < 7);
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] seed;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        kind;
    draw_t       typed_draw;
    int          sel;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    foreach (count_by_kind[i]) count_by_kind[i] = 0;
    expand_seed(32'h0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);

    // directed table on the reset seed
    foreach (directed_rows[i]) begin
      typed_draw.raw_word = directed_rows[i].exp_raw;
      typed_draw.range_value = directed_rows[i].exp_value;
      typed_draw.stepped = directed_rows[i].exp_stepped;
      send_request(directed_rows[i].kind, directed_rows[i].lo, directed_rows[i].hi,
                   directed_rows[i].typed, typed_draw);
    end
    s_axis_tvalid <= 1'b0;

    // seeded random phases
    for (int p = 0; p < PHASE_N; p++) begin
      drain_results();
      case (p)
        0: seed = 32'h0000_0000;
        1: seed = 32'h8000_0000;
        2: seed = 32'h7FFF_FFFF;
        3: seed = 32'hFFFF_FFFF;
        default: seed = $urandom();
      endcase
      write_seed(seed);
      idle_on = (p != 2);
      if (p == 4) begin
        holdoff_cycles = HOLDOFF_LEN;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(99);
        kind = REQ_RANGE;
        lo = $urandom();
        hi = $urandom();
        if (sel < 30) begin
          kind = REQ_RAW;
        end else if (sel < 42) begin
          if (sel < 36) begin
            lo = pick_bound();
          end
          hi = lo;
        end else if (sel < 58) begin
          hi = lo + $urandom_range(1, 40);
        end else if (sel < 72) begin
          hi = lo - $urandom_range(1, 40);
        end else if (sel < 86) begin
          lo = pick_bound();
          hi = pick_bound();
        end
        send_request(kind, lo, hi, 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
    end

    idle_on = 1'b1;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d results: %0d raw, %0d equal-bound, %0d rising, %0d falling draws",
             results_seen, count_by_kind[KIND_RAW], count_by_kind[KIND_HOLD],
             count_by_kind[KIND_UP], count_by_kind[KIND_DOWN]);
    $display("Seed loads: %0d (reset plus extremes and random seeds), mismatches: %0d",
             seed_loads, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/xsrg_pkg.sv
hw/rtl/xsrg_front.sv
hw/rtl/xsrg_fifo.sv
hw/rtl/xsrg_back.sv
hw/rtl/xorshift128_range_generator.sv
hw/rtl/xsrg_checker.sv
tb/xorshift128_range_generator_tb.sv
